// ===== hw/rtl/history_ring_with_line_rewind_macros.svh =====
// Assertion macros for the history ring with line rewind.
// Used by the top level; depends on a clk_i and rst_ni in the including scope.
`ifndef HISTORY_RING_WITH_LINE_REWIND_MACROS_SVH
`define HISTORY_RING_WITH_LINE_REWIND_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HRLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hrlr_pkg.sv =====
// Package for the history ring with line rewind: ring sizes, codes and states.
// No dependencies; imported by the top level.
`default_nettype none

package hrlr_pkg;

  localparam int unsigned RING_BYTES = 65536;
  localparam int unsigned RING_AW    = $clog2(RING_BYTES);
  localparam int unsigned RING_CW    = RING_AW + 1;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_REWIND = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RW_ISSUE,
    ST_RW_CHECK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/history_ring_with_line_rewind.sv =====
// Top level of the byte history ring with line rewind.
// Depends on hrlr_pkg and history_ring_with_line_rewind_macros.svh.
//
//  Group    Dir  tdata (low bit first)                         tuser
//  s_axis   in   data_byte, line_count, byte_budget, read_pos   action
//  m_axis   out  position, read_byte                            byte_valid
//
// A write beat gives no result; writes can follow one another in every
// cycle. A read reads the ring at the accepting edge, and the result is
// loaded into the output register from the done state once that register
// is free. A rewind with zero lines goes straight to the done state. A
// rewind that walks by lines reads the single port memory once per byte in
// the issue state, and the registered data is checked in the check state
// that follows; it stops at a newline or at the byte limit. Reset clears the
// byte count and the control state; the ring contents stay undefined until
// written. A stalled result sits in the output register and holds the block
// only when the next result is ready to be loaded.
`default_nettype none

module history_ring_with_line_rewind (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // data_byte[7:0], line_count[39:8], byte_budget[103:40], read_position[167:104]
  input  wire logic [167:0]  s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // position[63:0], read_byte[71:64]
  output logic [71:0]        m_axis_tdata,
  // byte_valid[0]
  output logic [0:0]         m_axis_tuser
);

  import hrlr_pkg::*;

  `include "history_ring_with_line_rewind_macros.svh"

  // Unpacked input fields.
  logic [7:0]  in_byte;
  logic [31:0] in_lines;
  logic [63:0] in_budget;
  logic [63:0] in_cursor;
  action_e     in_action;

  assign in_byte   = s_axis_tdata[7:0];
  assign in_lines  = s_axis_tdata[39:8];
  assign in_budget = s_axis_tdata[103:40];
  assign in_cursor = s_axis_tdata[167:104];
  assign in_action = action_e'(s_axis_tuser);

  state_e state_q, state_d;

  // Byte count, working registers of the current query, output register.
  logic [63:0]        head_q, head_d;
  logic [63:0]        pos_q, pos_d;
  logic [RING_CW-1:0] limit_q, limit_d;
  logic [RING_CW-1:0] back_q, back_d;
  logic [RING_CW-1:0] seen_q, seen_d;
  logic [31:0]        lines_q, lines_d;
  logic               bvalid_q, bvalid_d;
  logic               is_read_q, is_read_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_pos_q, out_pos_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_flag_q, out_flag_d;

  // Ring memory: one port, registered read data.
  logic [7:0]         ring_mem [RING_BYTES];
  logic [7:0]         rdata_q;
  logic               mem_we, mem_re;
  logic [RING_AW-1:0] mem_addr;

  logic in_fire, out_free, is_nl, walk_stop, walk_end;
  logic walking, wr_fire;
  logic [RING_CW-1:0] retained, limit_calc;
  logic [63:0]        oldest, cursor;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Status terms used by the checks at the end of the module.
  assign walking = (state_q == ST_RW_ISSUE) || (state_q == ST_RW_CHECK);
  assign wr_fire = in_fire && (in_action == ACT_WRITE);

  // The retained length saturates at the ring size once the count passes it.
  assign retained   = (head_q[63:RING_AW] != '0) ? RING_CW'(RING_BYTES)
                                                 : {1'b0, head_q[RING_AW-1:0]};
  assign limit_calc = (in_budget < {{(64 - RING_CW){1'b0}}, retained})
                      ? in_budget[RING_CW-1:0] : retained;

  // Oldest retained position; a read cursor below it is pulled up to it.
  assign oldest = (head_q > 64'(RING_BYTES)) ? head_q - 64'(RING_BYTES) : 64'd0;
  assign cursor = (in_cursor < oldest) ? oldest : in_cursor;

  // The walk stops before stepping over the newline that would exceed the
  // requested line count.
  assign is_nl     = (rdata_q == NEWLINE_CODE);
  assign walk_stop = is_nl && ({{(32 - RING_CW){1'b0}}, seen_q} == lines_q);
  assign walk_end  = (back_q == limit_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_REWIND: state_d = (in_lines == 32'd0) ? ST_DONE : ST_RW_ISSUE;
            ACT_READ:   state_d = ST_DONE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RW_ISSUE: state_d = walk_end ? ST_DONE : ST_RW_CHECK;
      ST_RW_CHECK: state_d = walk_stop ? ST_DONE : ST_RW_ISSUE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory control.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = head_q[RING_AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_action == ACT_WRITE) begin
          mem_we = 1'b1;
        end else if (in_fire && in_action == ACT_READ) begin
          mem_re   = 1'b1;
          mem_addr = cursor[RING_AW-1:0];
        end
      end
      ST_RW_ISSUE: begin
        mem_re   = !walk_end;
        mem_addr = head_q[RING_AW-1:0] - back_q[RING_AW-1:0] - RING_AW'(1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    head_d      = head_q;
    pos_d       = pos_q;
    limit_d     = limit_q;
    back_d      = back_q;
    seen_d      = seen_q;
    lines_d     = lines_q;
    bvalid_d    = bvalid_q;
    is_read_d   = is_read_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pos_d   = out_pos_q;
    out_byte_d  = out_byte_q;
    out_flag_d  = out_flag_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_WRITE: head_d = head_q + 64'd1;
            ACT_REWIND: begin
              limit_d   = limit_calc;
              lines_d   = in_lines;
              back_d    = '0;
              seen_d    = '0;
              is_read_d = 1'b0;
              bvalid_d  = 1'b0;
              pos_d     = head_q - {{(64 - RING_CW){1'b0}}, limit_calc};
            end
            ACT_READ: begin
              pos_d     = cursor;
              bvalid_d  = (cursor < head_q);
              is_read_d = 1'b1;
            end
            default: begin
              head_d = head_q;
            end
          endcase
        end
      end
      ST_RW_ISSUE: begin
        if (walk_end) begin
          pos_d = head_q - {{(64 - RING_CW){1'b0}}, back_q};
        end
      end
      ST_RW_CHECK: begin
        if (walk_stop) begin
          pos_d = head_q - {{(64 - RING_CW){1'b0}}, back_q};
        end else begin
          back_d = back_q + RING_CW'(1);
          seen_d = seen_q + RING_CW'(is_nl);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_byte_d  = (is_read_q && bvalid_q) ? rdata_q : 8'd0;
          out_flag_d  = is_read_q && bvalid_q;
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    limit_q    <= limit_d;
    back_q     <= back_d;
    seen_q     <= seen_d;
    lines_q    <= lines_d;
    bvalid_q   <= bvalid_d;
    is_read_q  <= is_read_d;
    out_pos_q  <= out_pos_d;
    out_byte_q <= out_byte_d;
    out_flag_q <= out_flag_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= in_byte;
    end
    if (mem_re) begin
      rdata_q <= ring_mem[mem_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_byte_q, out_pos_q};
  assign m_axis_tuser  = out_flag_q;

  // The walk never goes past the byte limit fixed when the query started.
  `HRLR_ASSERT_NOW(a_walk_in_limit, walking, (back_q <= limit_q), "walk passed its limit")
  // Beats are taken only when no query is in flight.
  `HRLR_ASSERT_NOW(a_ready_idle, s_axis_tready, (state_q == ST_IDLE), "ready outside idle")
  // Every accepted write advances the byte count by one.
  `HRLR_ASSERT_NEXT(a_write_count, wr_fire, (head_q == $past(head_q) + 64'd1), "count stalled")
  // A result appears only out of the result state.
  `HRLR_ASSERT_NEXT(a_out_src, (!out_valid_q && state_q != ST_DONE), !out_valid_q, "stray beat")

endmodule

`default_nettype wire
